@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/rtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Types and constants shared by the ray/triangle closest-hit unit.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORG_X = 3'd0,
        CFG_ORG_Y = 3'd1,
        CFG_ORG_Z = 3'd2,
        CFG_DIR_X = 3'd3,
        CFG_DIR_Y = 3'd4,
        CFG_DIR_Z = 3'd5,
        CFG_EPS   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vec_t;

    typedef struct packed {
        vec_t        e0;
        vec_t        e1;
        vec_t        tv;
        logic [23:0] id;
        logic        new_ray;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_out_t;

    typedef struct packed {
        vec_t        dir;
        logic [15:0] eps;
    } ray_t;

endpackage

@@ sv/rtc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_if
// Channel interfaces: triangle requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface rtc_tri_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p0_z;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_z;
    logic [23:0]        tri_id;
    logic               new_ray;

    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, tri_id, new_ray, input ready);
    modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, tri_id, new_ray, output ready);
endinterface

interface rtc_res_if;
    logic               valid;
    logic               ready;
    logic               took_hit;
    logic signed [31:0] hit_t;
    logic signed [31:0] nearest_t;
    logic [23:0]        nearest_id;
    logic               any_hit;

    modport source (output valid, took_hit, hit_t, nearest_t, nearest_id, any_hit,
                    input ready);
    modport sink (input valid, took_hit, hit_t, nearest_t, nearest_id, any_hit,
                  output ready);
endinterface

interface rtc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/rtc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_front
// Configuration registers, triangle accept, edge forming and request queue.
// ----------------------------------------------------------------------------
module rtc_front #(
    parameter int ID_BITS         = 24,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    rtc_tri_if.sink             triangle,
    rtc_cfg_if.sink             cfg,
    input  logic                pop,
    output rtc_pkg::queue_out_t q_out,
    output rtc_pkg::ray_t       ray
);
    import rtc_pkg::*;

    localparam int DEPTH = 2;

    logic [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [31:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [15:0] eps_reg;

    job_t        entry_reg [DEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        accept;
    job_t        job_in;
    logic [23:0] id_m;

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
            sat_sub = d[32] ? 32'h8000_0000 : T_MAX;
        else
            sat_sub = d[31:0];
    endfunction

    assign cfg.ready      = 1'b1;
    assign triangle.ready = (count_reg != 2'(DEPTH));
    assign accept         = triangle.valid && triangle.ready;

    always_comb
    begin
        for (int i = 0; i < 24; i++)
            id_m[i] = (i < ID_BITS) ? triangle.tri_id[i] : 1'b0;
    end

    always_comb
    begin
        job_in.e0.x    = sat_sub(triangle.p1_x, triangle.p0_x);
        job_in.e0.y    = sat_sub(triangle.p1_y, triangle.p0_y);
        job_in.e0.z    = sat_sub(triangle.p1_z, triangle.p0_z);
        job_in.e1.x    = sat_sub(triangle.p2_x, triangle.p0_x);
        job_in.e1.y    = sat_sub(triangle.p2_y, triangle.p0_y);
        job_in.e1.z    = sat_sub(triangle.p2_z, triangle.p0_z);
        job_in.tv.x    = sat_sub(org_x_reg, triangle.p0_x);
        job_in.tv.y    = sat_sub(org_y_reg, triangle.p0_y);
        job_in.tv.z    = sat_sub(org_z_reg, triangle.p0_z);
        job_in.id      = id_m;
        job_in.new_ray = triangle.new_ray;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= 32'(64'd1 << COORD_FRAC_BITS);
            eps_reg   <= 16'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_ORG_X: org_x_reg <= cfg.data;
                CFG_ORG_Y: org_y_reg <= cfg.data;
                CFG_ORG_Z: org_z_reg <= cfg.data;
                CFG_DIR_X: dir_x_reg <= cfg.data;
                CFG_DIR_Y: dir_y_reg <= cfg.data;
                CFG_DIR_Z: dir_z_reg <= cfg.data;
                CFG_EPS:   eps_reg   <= cfg.data[15:0];
                default:   ;
            endcase
        end
    end

    // request queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(accept) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg[wr_ptr_reg] <= job_in;
    end

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.job   = entry_reg[rd_ptr_reg];
    assign ray.dir.x   = dir_x_reg;
    assign ray.dir.y   = dir_y_reg;
    assign ray.dir.z   = dir_z_reg;
    assign ray.eps     = eps_reg;

endmodule

@@ sv/rtc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_back
// Shared-multiplier sequencer, serial divider and nearest-hit tracking.
// ----------------------------------------------------------------------------
module rtc_back #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rtc_pkg::queue_out_t q_out,
    input  rtc_pkg::ray_t       ray,
    output logic                pop,
    rtc_res_if.source           result
);
    import rtc_pkg::*;

    localparam int DW     = 32 + COORD_FRAC_BITS;
    localparam int DCNT_W = $clog2(DW + 1);
    localparam int STEPS  = 24;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_DONE} state_t;

    typedef enum logic [3:0] {
        D_NONE, D_PV_X, D_PV_Y, D_PV_Z, D_DET, D_QV_X, D_QV_Y, D_QV_Z,
        D_NU, D_NV, D_NT
    } dest_t;

    typedef struct packed {
        logic  first;
        logic  neg;
        logic  last;
        dest_t dest;
    } step_t;

    state_t             state_reg;
    job_t               job_reg;
    logic [4:0]         cnt_reg;
    logic signed [63:0] mul_reg, acc_reg;
    vec_t               pv_reg, qv_reg;
    logic [31:0]        det_reg, nu_reg, nv_reg, nt_reg;
    logic [DW-1:0]      num_reg, q_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        dvs_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               hit_reg;
    logic [31:0]        best_t_reg;
    logic [23:0]        best_id_reg;
    logic               have_reg;

    logic               out_valid_reg, out_took_reg, out_any_reg;
    logic [31:0]        out_hit_t_reg, out_near_t_reg;
    logic [23:0]        out_near_id_reg;

    logic [31:0]        op_a, op_b;
    step_t              info;
    logic signed [63:0] prod_sh, sum_next;
    logic               det_neg, reject;
    logic [31:0]        det_abs, nt_abs;
    logic signed [33:0] nu_a, nv_a;
    logic [32:0]        rem_sh;
    logic               q_bit;
    logic [31:0]        t_sat, base_t;
    logic               took;
    logic               slot_free;

    function automatic step_t step_info(input logic [4:0] s);
        step_t r;
        r = '{first: 1'b0, neg: 1'b0, last: 1'b0, dest: D_NONE};
        case (s)
            5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd11, 5'd13, 5'd15, 5'd18, 5'd21:
                r.first = 1'b1;
            default: ;
        endcase
        case (s)
            5'd1:  begin r.neg = 1'b1; r.last = 1'b1; r.dest = D_PV_X; end
            5'd3:  begin r.neg = 1'b1; r.last = 1'b1; r.dest = D_PV_Y; end
            5'd5:  begin r.neg = 1'b1; r.last = 1'b1; r.dest = D_PV_Z; end
            5'd8:  begin r.last = 1'b1; r.dest = D_DET; end
            5'd10: begin r.neg = 1'b1; r.last = 1'b1; r.dest = D_QV_X; end
            5'd12: begin r.neg = 1'b1; r.last = 1'b1; r.dest = D_QV_Y; end
            5'd14: begin r.neg = 1'b1; r.last = 1'b1; r.dest = D_QV_Z; end
            5'd17: begin r.last = 1'b1; r.dest = D_NU; end
            5'd20: begin r.last = 1'b1; r.dest = D_NV; end
            5'd23: begin r.last = 1'b1; r.dest = D_NT; end
            default: ;
        endcase
        step_info = r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > $signed(64'h0000_0000_7FFF_FFFF))
            sat32 = T_MAX;
        else if (v < $signed(64'hFFFF_FFFF_8000_0000))
            sat32 = 32'h8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    // operand select for the shared multiplier
    always_comb
    begin
        case (cnt_reg)
            5'd0:  begin op_a = ray.dir.y;    op_b = job_reg.e1.z; end
            5'd1:  begin op_a = ray.dir.z;    op_b = job_reg.e1.y; end
            5'd2:  begin op_a = ray.dir.z;    op_b = job_reg.e1.x; end
            5'd3:  begin op_a = ray.dir.x;    op_b = job_reg.e1.z; end
            5'd4:  begin op_a = ray.dir.x;    op_b = job_reg.e1.y; end
            5'd5:  begin op_a = ray.dir.y;    op_b = job_reg.e1.x; end
            5'd6:  begin op_a = job_reg.e0.x; op_b = pv_reg.x;     end
            5'd7:  begin op_a = job_reg.e0.y; op_b = pv_reg.y;     end
            5'd8:  begin op_a = job_reg.e0.z; op_b = pv_reg.z;     end
            5'd9:  begin op_a = job_reg.tv.y; op_b = job_reg.e0.z; end
            5'd10: begin op_a = job_reg.tv.z; op_b = job_reg.e0.y; end
            5'd11: begin op_a = job_reg.tv.z; op_b = job_reg.e0.x; end
            5'd12: begin op_a = job_reg.tv.x; op_b = job_reg.e0.z; end
            5'd13: begin op_a = job_reg.tv.x; op_b = job_reg.e0.y; end
            5'd14: begin op_a = job_reg.tv.y; op_b = job_reg.e0.x; end
            5'd15: begin op_a = job_reg.tv.x; op_b = pv_reg.x;     end
            5'd16: begin op_a = job_reg.tv.y; op_b = pv_reg.y;     end
            5'd17: begin op_a = job_reg.tv.z; op_b = pv_reg.z;     end
            5'd18: begin op_a = ray.dir.x;    op_b = qv_reg.x;     end
            5'd19: begin op_a = ray.dir.y;    op_b = qv_reg.y;     end
            5'd20: begin op_a = ray.dir.z;    op_b = qv_reg.z;     end
            5'd21: begin op_a = job_reg.e1.x; op_b = qv_reg.x;     end
            5'd22: begin op_a = job_reg.e1.y; op_b = qv_reg.y;     end
            5'd23: begin op_a = job_reg.e1.z; op_b = qv_reg.z;     end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb
    begin
        info     = step_info(cnt_reg - 5'd1);
        prod_sh  = mul_reg >>> COORD_FRAC_BITS;
        sum_next = (info.first ? 64'sd0 : acc_reg) + (info.neg ? -prod_sh : prod_sh);
    end

    always_comb
    begin
        det_neg = det_reg[31];
        det_abs = det_neg ? (~det_reg + 32'd1) : det_reg;
        nt_abs  = nt_reg[31] ? (~nt_reg + 32'd1) : nt_reg;
        nu_a    = det_neg ? -34'(signed'(nu_reg)) : 34'(signed'(nu_reg));
        nv_a    = det_neg ? -34'(signed'(nv_reg)) : 34'(signed'(nv_reg));
        reject  = (det_reg == 32'd0) || (det_abs < {16'd0, ray.eps}) || nu_a[33] || nv_a[33]
                  || ((nu_a + nv_a) > $signed({2'b00, det_abs}))
                  || (nt_reg[31] != det_neg);
    end

    always_comb
    begin
        rem_sh = {rem_reg[31:0], num_reg[DW-1]};
        q_bit  = (rem_sh >= {1'b0, dvs_reg});
        t_sat  = (q_reg > DW'(T_MAX)) ? T_MAX : q_reg[31:0];
        base_t = job_reg.new_ray ? T_MAX : best_t_reg;
        took   = hit_reg && (q_reg != '0) && ($signed(t_sat) < $signed(base_t));
        slot_free = !out_valid_reg || result.ready;
    end

    assign pop = (state_reg == S_IDLE) && q_out.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            best_t_reg    <= T_MAX;
            best_id_reg   <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_out.valid)
                    begin
                        job_reg   <= q_out.job;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg < 5'(STEPS))
                        mul_reg <= $signed(op_a) * $signed(op_b);
                    if (cnt_reg != 5'd0)
                    begin
                        acc_reg <= sum_next;
                        case (info.dest)
                            D_PV_X: pv_reg.x <= sat32(sum_next);
                            D_PV_Y: pv_reg.y <= sat32(sum_next);
                            D_PV_Z: pv_reg.z <= sat32(sum_next);
                            D_DET:  det_reg  <= sat32(sum_next);
                            D_QV_X: qv_reg.x <= sat32(sum_next);
                            D_QV_Y: qv_reg.y <= sat32(sum_next);
                            D_QV_Z: qv_reg.z <= sat32(sum_next);
                            D_NU:   nu_reg   <= sat32(sum_next);
                            D_NV:   nv_reg   <= sat32(sum_next);
                            D_NT:   nt_reg   <= sat32(sum_next);
                            default: ;
                        endcase
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(STEPS))
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    hit_reg  <= !reject;
                    q_reg    <= '0;
                    rem_reg  <= '0;
                    dvs_reg  <= det_abs;
                    num_reg  <= {nt_abs, {COORD_FRAC_BITS{1'b0}}};
                    dcnt_reg <= DCNT_W'(DW);
                    state_reg <= reject ? S_DONE : S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                    q_reg    <= {q_reg[DW-2:0], q_bit};
                    num_reg  <= {num_reg[DW-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        best_t_reg      <= took ? t_sat : base_t;
                        best_id_reg     <= took ? job_reg.id
                                                : (job_reg.new_ray ? 24'd0 : best_id_reg);
                        have_reg        <= took || (have_reg && !job_reg.new_ray);
                        out_valid_reg   <= 1'b1;
                        out_took_reg    <= took;
                        out_hit_t_reg   <= took ? t_sat : 32'd0;
                        out_near_t_reg  <= took ? t_sat : base_t;
                        out_near_id_reg <= took ? job_reg.id
                                                : (job_reg.new_ray ? 24'd0 : best_id_reg);
                        out_any_reg     <= took || (have_reg && !job_reg.new_ray);
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.took_hit   = out_took_reg;
    assign result.hit_t      = out_hit_t_reg;
    assign result.nearest_t  = out_near_t_reg;
    assign result.nearest_id = out_near_id_reg;
    assign result.any_hit    = out_any_reg;

endmodule

@@ sv/ray_triangle_closest_hit.sv @@
// A rejected triangle goes from accept to result without the distance divide;
// one that passes the checks also runs the serial divider before its result.
// The back end takes one triangle at a time, paced by the single shared
// multiplier (24 products) and the one-bit-per-cycle restoring divider.
// A two-entry request queue and an output register decouple both sides.
// Reset (rst_n low, asynchronous) restores the ray registers and clears the nearest hit.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit
// Closest-hit ray/triangle test over a stream of triangles.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit #(
    parameter int ID_BITS         = 24,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rtc_tri_if.sink   triangle,
    rtc_res_if.source result,
    rtc_cfg_if.sink   cfg
);
    import rtc_pkg::*;

    queue_out_t q_out;
    ray_t       ray;
    logic       pop;

    rtc_front #(
        .ID_BITS(ID_BITS),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .triangle(triangle),
        .cfg(cfg),
        .pop(pop),
        .q_out(q_out),
        .ray(ray)
    );

    rtc_back #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_out(q_out),
        .ray(ray),
        .pop(pop),
        .result(result)
    );

endmodule

@@ sv/rtc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_props
// Port-level checks on the result channel of the closest-hit unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtc_props (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        took_hit,
    input logic [31:0] hit_t,
    input logic [31:0] nearest_t,
    input logic        any_hit
);

    `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
    `ASSERT_IMPL(a_took_any, res_valid && took_hit, any_hit)
    `ASSERT_IMPL(a_took_near, res_valid && took_hit, nearest_t == hit_t)
    `ASSERT_IMPL(a_miss_zero, res_valid && !took_hit, hit_t == 32'd0)

endmodule

bind ray_triangle_closest_hit rtc_props u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(result.valid),
    .res_ready(result.ready),
    .took_hit(result.took_hit),
    .hit_t(result.hit_t),
    .nearest_t(result.nearest_t),
    .any_hit(result.any_hit)
);
